[sv/pfq_pkg.sv]
// ----------------------------------------------------------------------------
// pfq_pkg - shared types for the process queue
// Item structs, operation and status codes, controller/datapath handshake.
// ----------------------------------------------------------------------------
package pfq_pkg;

  localparam int HANDLE_W   = 16;
  localparam int ID_FIELD_W = 16;
  localparam int COUNT_W    = 5;

  typedef enum logic [1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_ZERO = 2'd3
  } status_t;

  // which logical slot (relative to head) the read port fetches
  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_K1   = 2'd1,
    RD_K2   = 2'd2
  } rd_off_t;

  typedef struct packed {
    func_t                 func;
    logic [HANDLE_W-1:0]   proc_handle;
    logic [ID_FIELD_W-1:0] proc_id;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   out_handle;
    logic [ID_FIELD_W-1:0] out_id;
    logic [COUNT_W-1:0]    count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;      // latch search id
    logic    push_wr;   // write input entry at tail
    logic    shift_wr;  // write read data at slot k
    logic    rd_en;
    rd_off_t rd_off;
    logic    k_clr;
    logic    k_inc;
    logic    hold_ld;   // keep matched entry
    logic    adv_head;
    logic    inc_occ;
    logic    dec_occ;
    logic    fin;       // issue result
    status_t st;
    logic    take;      // result carries an entry
    logic    from_hold; // entry from hold register, else read data
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic id_zero;  // incoming id is zero after masking
    logic match;    // read data id equals search id
    logic k_zero;
    logic k_last;   // k is the last occupied slot
    logic k1_last;  // k+1 is the last occupied slot
  } sts_t;

endpackage

[sv/pfq_ram.sv]
// ----------------------------------------------------------------------------
// pfq_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/pfq_dp.sv]
// ----------------------------------------------------------------------------
// pfq_dp - process queue datapath
// Circular entry store, head/occupancy/scan registers, result register.
// ----------------------------------------------------------------------------
module pfq_dp #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pfq_pkg::in_item_t in_item,
  input  pfq_pkg::cmd_t     cmd,
  output pfq_pkg::sts_t     sts,
  output logic              out_valid,
  output pfq_pkg::out_item_t out_item
);
  import pfq_pkg::*;

  localparam int PW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int EW  = PW + 2;
  localparam int IDW = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
  localparam int ENW = HANDLE_W + IDW;

  // base + off, wrapped into 0..DEPTH-1; both operands below DEPTH
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                             input logic [PW:0]   off);
    logic [PW:0] s;
    s = {1'b0, base} + off;
    if (s >= (PW+1)'(DEPTH)) begin
      s = s - (PW+1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  logic [PW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  occ_r, occ_nxt;
  logic [PW-1:0]  k_r, k_nxt;
  logic [IDW-1:0] item_id_r;
  func_t          item_func_r;
  logic [ENW-1:0] hold_r;
  logic           out_valid_r;
  out_item_t      out_item_r;

  logic [IDW-1:0] in_id;
  logic [ENW-1:0] rdata, wdata, ent;
  logic [PW-1:0]  waddr, raddr;
  logic [PW:0]    rd_log;
  logic           we;
  logic [EW-1:0]  kx, ox;

  assign in_id = in_item.proc_id[IDW-1:0];
  assign kx    = EW'(k_r);
  assign ox    = EW'(occ_r);

  always_comb begin
    sts.empty   = (occ_r == '0);
    sts.full    = (occ_r == CW'(DEPTH));
    sts.id_zero = (in_id == '0);
    sts.match   = (rdata[IDW-1:0] == item_id_r);
    sts.k_zero  = (k_r == '0);
    sts.k_last  = ((kx + EW'(1)) == ox);
    sts.k1_last = ((kx + EW'(2)) == ox);
  end

  // read address
  always_comb begin
    case (cmd.rd_off)
      RD_ZERO: rd_log = '0;
      RD_K1:   rd_log = (PW+1)'(k_r) + (PW+1)'(1);
      RD_K2:   rd_log = (PW+1)'(k_r) + (PW+1)'(2);
      default: rd_log = '0;
    endcase
    raddr = wrap_add(head_r, rd_log);
  end

  // write port: push at tail, or shift down to slot k
  always_comb begin
    we = cmd.push_wr | cmd.shift_wr;
    if (cmd.push_wr) begin
      waddr = wrap_add(head_r, (PW+1)'(occ_r));
      wdata = {in_item.proc_handle, in_id};
    end else begin
      waddr = wrap_add(head_r, (PW+1)'(k_r));
      wdata = rdata;
    end
  end

  pfq_ram #(
    .WIDTH (ENW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    head_nxt = cmd.adv_head ? wrap_add(head_r, (PW+1)'(1)) : head_r;
    occ_nxt  = occ_r;
    if (cmd.inc_occ) begin
      occ_nxt = occ_r + CW'(1);
    end else if (cmd.dec_occ) begin
      occ_nxt = occ_r - CW'(1);
    end
    k_nxt = k_r;
    if (cmd.k_clr) begin
      k_nxt = '0;
    end else if (cmd.k_inc) begin
      k_nxt = k_r + PW'(1);
    end
    ent = cmd.from_hold ? hold_r : rdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      k_r         <= k_nxt;
      out_valid_r <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_id_r   <= in_id;
      item_func_r <= in_item.func;
    end
    if (cmd.hold_ld) begin
      hold_r <= rdata;
    end
    if (cmd.fin) begin
      out_item_r.status     <= cmd.st;
      out_item_r.out_handle <= cmd.take ? ent[ENW-1:IDW] : '0;
      out_item_r.out_id     <= cmd.take ? ID_FIELD_W'(ent[IDW-1:0]) : '0;
      out_item_r.count      <= COUNT_W'(occ_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == ST_FULL |-> occ_r == CW'(DEPTH))
    else $error("full status with free slots");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == ST_OK && item_func_r == FN_REMOVE
      && $past(rst_n)
    |-> (EW'(occ_r) + EW'(1)) == EW'($past(occ_r)))
    else $error("remove hit did not shrink queue by one");

endmodule

[sv/pfq_ctrl.sv]
// ----------------------------------------------------------------------------
// pfq_ctrl - process queue controller
// Decodes operations, steps the id search and the gap-closing shift.
// ----------------------------------------------------------------------------
module pfq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pfq_pkg::in_item_t in_item,
  input  pfq_pkg::sts_t     sts,
  output pfq_pkg::cmd_t     cmd,
  output logic              busy
);
  import pfq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_CMP  = 4'b0100,
    S_SHW  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (in_item.func)
            FN_PUSH: begin
              cmd.fin     = 1'b1;
              cmd.st      = sts.full ? ST_FULL : ST_OK;
              cmd.push_wr = !sts.full;
              cmd.inc_occ = !sts.full;
            end
            FN_POP: begin
              if (sts.empty) begin
                cmd.fin = 1'b1;
                cmd.st  = ST_MISS;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_off = RD_ZERO;
                state_nxt  = S_POP;
              end
            end
            FN_REMOVE: begin
              if (sts.id_zero) begin
                cmd.fin = 1'b1;
                cmd.st  = ST_ZERO;
              end else if (sts.empty) begin
                cmd.fin = 1'b1;
                cmd.st  = ST_MISS;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_off = RD_ZERO;
                cmd.k_clr  = 1'b1;
                state_nxt  = S_CMP;
              end
            end
            default: begin
              cmd.fin = 1'b1;
              cmd.st  = ST_OK;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.fin      = 1'b1;
        cmd.st       = ST_OK;
        cmd.take     = 1'b1;
        cmd.adv_head = 1'b1;
        cmd.dec_occ  = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CMP: begin
        if (sts.match) begin
          if (sts.k_zero) begin
            // head hit: same as a pop
            cmd.fin      = 1'b1;
            cmd.st       = ST_OK;
            cmd.take     = 1'b1;
            cmd.adv_head = 1'b1;
            cmd.dec_occ  = 1'b1;
            state_nxt    = S_IDLE;
          end else if (sts.k_last) begin
            // tail hit: nothing to shift
            cmd.fin     = 1'b1;
            cmd.st      = ST_OK;
            cmd.take    = 1'b1;
            cmd.dec_occ = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.hold_ld = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_off  = RD_K1;
            state_nxt   = S_SHW;
          end
        end else if (sts.k_last) begin
          cmd.fin   = 1'b1;
          cmd.st    = ST_MISS;
          state_nxt = S_IDLE;
        end else begin
          cmd.k_inc  = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_off = RD_K1;
        end
      end
      S_SHW: begin
        cmd.shift_wr = 1'b1;
        if (sts.k1_last) begin
          cmd.fin       = 1'b1;
          cmd.st        = ST_OK;
          cmd.take      = 1'b1;
          cmd.from_hold = 1'b1;
          cmd.dec_occ   = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.k_inc  = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_off = RD_K2;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP || state_r == S_SHW || state_r == S_POP) |-> !sts.empty)
    else $error("walking an empty queue");

  a_shift_has_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHW && !$past(state_r == S_SHW) |-> $past(cmd.hold_ld))
    else $error("shift entered without a held entry");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP && !sts.match && sts.k_last |-> cmd.fin && cmd.st == ST_MISS)
    else $error("search ran past the last entry");

endmodule

[sv/process_fifo_with_remove_by_id_top.sv]
// ----------------------------------------------------------------------------
// process_fifo_with_remove_by_id_top - ordered process queue, keyed removal
// Arrival-ordered queue of (handle, id) entries with push, pop and remove.
// ----------------------------------------------------------------------------
// Drive start with an item while busy is low; it is taken at that edge. Each
// item gives exactly one result, shown for one cycle with out_valid high; the
// receiver cannot stall it, so capture it on that edge. Push (and any item
// rejected up front: empty pop, zero-id or empty remove, push when full,
// unused code) finishes from idle with busy never rising. Pop reads the head
// entry, then issues it and advances the head. Remove walks the queue from
// the head, one entry per cycle through the RAM read port, and then closes
// the gap by moving each later entry down one slot, one per cycle. A head hit
// only moves the head pointer, a tail hit only trims the count. Entries live
// in a circular buffer in one RAM, so no clearing pass is needed after reset.
// Every result carries the count after the operation (low five bits).
// ----------------------------------------------------------------------------
module process_fifo_with_remove_by_id_top #(
  parameter int DEPTH   = 16,  // 2..256 entries
  parameter int ID_BITS = 16   // ids kept to this many bits (at most 16), 8..32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pfq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pfq_pkg::out_item_t out_item
);
  import pfq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: decode, search walk, shift walk
  pfq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // storage, pointers, result register
  pfq_dp #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
